// ===== hw/rtl/ise_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ise_pkg: shared types and constants of the insertion sort engine
// Beat structs, cell control struct, sizing constants and the control states.
// ----------------------------------------------------------------------------
package ise_pkg;

  // Number of cells in the sorting chain.
  localparam int MAX_ITEMS = 64;
  // Fill counter width; it must hold MAX_ITEMS itself.
  localparam int CNT_W = $clog2(MAX_ITEMS + 1);
  localparam int VAL_W = 32;
  localparam int RANK_W = 6;

  typedef struct packed {
    logic signed [VAL_W-1:0] sample;
    logic                    set_end;
  } in_beat_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] sorted_value;
    logic [RANK_W-1:0]       rank;
    logic                    final_result;
    logic                    overflow;
  } out_beat_t;

  // Control broadcast to every cell of the chain.
  typedef struct packed {
    logic                    insert;
    logic                    shift_down;
    logic signed [VAL_W-1:0] sample;
  } cell_ctrl_t;

  typedef enum logic {
    ST_FILL,
    ST_DRAIN
  } ise_state_t;

endpackage
`default_nettype wire

// ===== hw/rtl/ise_cell.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ise_cell: one cell of the insertion sort chain
// Holds one stored value; takes the new sample or its lower neighbor's value
// on insert, and its upper neighbor's value when the chain drains.
// ----------------------------------------------------------------------------
module ise_cell (
  input  wire logic                           clk,
  input  wire ise_pkg::cell_ctrl_t            ctrl,
  input  wire logic                           occupied,
  input  wire logic signed [ise_pkg::VAL_W-1:0] lower_value,
  input  wire logic                           lower_move,
  input  wire logic signed [ise_pkg::VAL_W-1:0] upper_value,
  output logic signed [ise_pkg::VAL_W-1:0]    value,
  output logic                                move
);
  import ise_pkg::*;

  logic signed [VAL_W-1:0] value_next;

  // An empty cell counts as larger than any sample, so the first empty cell
  // takes the sample when every stored value is smaller or equal.
  assign move = !occupied || (value > ctrl.sample);

  always_comb begin
    value_next = value;
    if (ctrl.shift_down) begin
      value_next = upper_value;
    end else if (ctrl.insert && move) begin
      value_next = lower_move ? lower_value : ctrl.sample;
    end
  end

  always_ff @(posedge clk) begin
    value <= value_next;
  end

endmodule
`default_nettype wire

// ===== hw/rtl/insertion_sort_engine_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// insertion_sort_engine_unit: systolic insertion sorter for signed values
// A chain of MAX_ITEMS cells keeps the current set in ascending order and
// drains it through an output register when a beat marked set_end arrives.
// ----------------------------------------------------------------------------
// Throughput: beats without set_end are taken one per cycle while filling,
//   since the whole chain inserts a value in a single step.
// A set_end beat switches the control state to drain; each drain step moves
//   one result into the output register, at one per cycle while the
//   consumer keeps ready high, and no input is taken until the drain is over.
// Reset clears the fill count, the overflow flag, the control state and the
//   output valid; cell contents are not cleared and need no clearing pass.
module insertion_sort_engine_unit (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire ise_pkg::in_beat_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output ise_pkg::out_beat_t      out_data
);
  import ise_pkg::*;

  ise_state_t        state, state_next;
  logic [CNT_W-1:0]  fill_count, fill_count_next;
  logic              dropped_flag, dropped_flag_next;
  logic [RANK_W-1:0] rank_count, rank_count_next;
  logic              out_valid_next;

  logic              in_fire;
  logic              has_room;
  logic              out_load;
  cell_ctrl_t        ctrl;

  logic signed [VAL_W-1:0] cell_value [MAX_ITEMS];
  logic                    cell_move  [MAX_ITEMS];

  // Input is taken only while filling; the chain is empty again once the
  // last result has moved into the output register, so a waiting final beat
  // does not hold back the next set.
  assign in_ready = (state == ST_FILL);
  assign in_fire  = in_valid && in_ready;
  assign has_room = (fill_count < CNT_W'(MAX_ITEMS));

  // During a drain a result moves into the output register whenever it is
  // empty or its beat is being taken this cycle.
  assign out_load = (state == ST_DRAIN) && (!out_valid || out_ready);

  assign ctrl.insert     = in_fire && has_room;
  assign ctrl.shift_down = out_load;
  assign ctrl.sample     = in_data.sample;

  // The chain: cell zero holds the smallest value. On insert every cell
  // holding a larger value moves up one place, fed by its lower neighbor;
  // on drain every cell takes the value of its upper neighbor.
  for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
    logic signed [VAL_W-1:0] lower_value;
    logic                    lower_move;
    logic signed [VAL_W-1:0] upper_value;

    if (i == 0) begin : g_bottom
      assign lower_value = in_data.sample;
      assign lower_move  = 1'b0;
    end else begin : g_inner_lo
      assign lower_value = cell_value[i-1];
      assign lower_move  = cell_move[i-1];
    end

    if (i == MAX_ITEMS - 1) begin : g_top
      assign upper_value = cell_value[i];
    end else begin : g_inner_hi
      assign upper_value = cell_value[i+1];
    end

    ise_cell u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .occupied    (fill_count > CNT_W'(i)),
      .lower_value (lower_value),
      .lower_move  (lower_move),
      .upper_value (upper_value),
      .value       (cell_value[i]),
      .move        (cell_move[i])
    );
  end

  // Control: while filling, fill_count counts stored values; while draining
  // it counts the values still in the chain.
  always_comb begin
    state_next        = state;
    fill_count_next   = fill_count;
    dropped_flag_next = dropped_flag;
    rank_count_next   = rank_count;
    case (state)
      ST_FILL: begin
        if (in_fire) begin
          if (has_room) begin
            fill_count_next = fill_count + CNT_W'(1);
          end else begin
            dropped_flag_next = 1'b1;
          end
          if (in_data.set_end) begin
            state_next      = ST_DRAIN;
            rank_count_next = '0;
          end
        end
      end
      ST_DRAIN: begin
        if (out_load) begin
          fill_count_next = fill_count - CNT_W'(1);
          rank_count_next = rank_count + RANK_W'(1);
          if (fill_count == CNT_W'(1)) begin
            state_next        = ST_FILL;
            dropped_flag_next = 1'b0;
          end
        end
      end
      default: begin
        state_next = ST_FILL;
      end
    endcase
  end

  always_comb begin
    out_valid_next = out_valid;
    if (out_load) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_FILL;
      fill_count   <= '0;
      dropped_flag <= 1'b0;
      rank_count   <= '0;
      out_valid    <= 1'b0;
    end else begin
      state        <= state_next;
      fill_count   <= fill_count_next;
      dropped_flag <= dropped_flag_next;
      rank_count   <= rank_count_next;
      out_valid    <= out_valid_next;
    end
  end

  // Output register: payload only, no reset needed.
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data.sorted_value <= cell_value[0];
      out_data.rank         <= rank_count;
      out_data.final_result <= (fill_count == CNT_W'(1));
      out_data.overflow     <= dropped_flag;
    end
  end

endmodule
`default_nettype wire
